/* rtl/mexp_pkg.sv */
// ============================================================================
// mexp_pkg: shared types for the modular exponentiation block
// Holds the data width, the status word of the modular multiply unit, the
// sequencer state type and the configuration port's register index codes.
// ============================================================================
`default_nettype none

package mexp_pkg;

  // Width of every data port of the block.
  localparam int DATA_BITS = 64;

  // Register index codes, taken from paddr[3].
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // Status of the shared modular multiply unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_MULT   = 4'b0100,
    ST_SQUARE = 4'b1000
  } state_t;

endpackage : mexp_pkg

`default_nettype wire

/* rtl/mexp_modmul.sv */
// ============================================================================
// mexp_modmul: bit-serial modular multiplier
// Forms (a * b) mod m by double-and-add, one multiplier bit per cycle,
// most significant bit first. Also serves as a reducer with a = 1.
// ============================================================================
`default_nettype none

module mexp_modmul #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] m,
  output logic      [WIDTH-1:0] result,
  output mexp_pkg::mm_sts_t     sts
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] bsh_r, bsh_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] step;

  // (x + y) mod mm for x and y both below mm, without leaving the word.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] mm);
    logic [WIDTH-1:0] gap;
    begin
      gap = mm - y;
      if (x >= gap) add_mod = x - gap;
      else          add_mod = x + y;
    end
  endfunction

  always_comb begin
    dbl  = add_mod(acc_r, acc_r, m_r);
    step = bsh_r[WIDTH-1] ? add_mod(dbl, a_r, m_r) : dbl;
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    m_nxt    = m_r;
    bsh_nxt  = bsh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      acc_nxt  = '0;
      a_nxt    = a;
      m_nxt    = m;
      bsh_nxt  = b;
      cnt_nxt  = CW'(WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = step;
      bsh_nxt = {bsh_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    m_r   <= m_nxt;
    bsh_r <= bsh_nxt;
  end

  assign result   = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule : mexp_modmul

`default_nettype wire

/* rtl/modular_exponentiation.sv */
// ============================================================================
// modular_exponentiation: base ^ exponent mod modulus, square and multiply
// A small sequencer drives one bit-serial modular multiplier to reduce the
// base and then scan the exponent from its least significant bit upward.
// ============================================================================
// Each word costs a reduction of the base, a squaring for each exponent bit up
// to its highest one bit and a multiply for each one bit, all on the multiplier.
// A new word is taken only once the last result is out; busy drops as the strobe
// rises, and out_valid is high one cycle per result since the receiver cannot
// stall. Reset is synchronous, active low, and sets modulus to 1, exponent to 0.
`default_nettype none

module modular_exponentiation #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel.
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mexp_pkg::DATA_BITS-1:0] in_base_value,
  // Result channel.
  output logic                                out_valid,
  output logic      [mexp_pkg::DATA_BITS-1:0] out_power_residue,
  // Configuration port, APB style.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [3:0]                     paddr,
  input  wire logic [mexp_pkg::DATA_BITS-1:0] pwdata,
  output logic      [mexp_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready
);

  localparam int W = WORD_BITS;

  // Configuration registers. Writes keep only the low WORD_BITS bits, and a
  // modulus write that is zero in those bits leaves the modulus untouched.
  logic [W-1:0] modulus_r, modulus_nxt;
  logic [W-1:0] exponent_r, exponent_nxt;
  logic         wr_en;
  logic [W-1:0] wr_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_val = pwdata[W-1:0];

  always_comb begin
    modulus_nxt  = modulus_r;
    exponent_nxt = exponent_r;
    if (wr_en) begin
      case (paddr[3])
        mexp_pkg::REG_MODULUS: begin
          if (wr_val != '0) modulus_nxt = wr_val;
        end
        mexp_pkg::REG_EXPONENT: begin
          exponent_nxt = wr_val;
        end
        default: begin
          modulus_nxt = modulus_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      mexp_pkg::REG_MODULUS:  prdata = mexp_pkg::DATA_BITS'(modulus_r);
      mexp_pkg::REG_EXPONENT: prdata = mexp_pkg::DATA_BITS'(exponent_r);
      default:                prdata = '0;
    endcase
  end

  // Sequencer state and the working values of one item: the reduced and
  // repeatedly squared base, the running result and the remaining exponent.
  mexp_pkg::state_t  state_r, state_nxt;
  logic [W-1:0]      base_r, base_nxt;
  logic [W-1:0]      bv_r, bv_nxt;
  logic [W-1:0]      res_r, res_nxt;
  logic [W-1:0]      e_r, e_nxt;
  logic [W-1:0]      e_dec;
  logic              go_r, go_nxt;
  logic              ov_r, ov_nxt;
  logic [W-1:0]      ores_r, ores_nxt;

  // Shared multiplier.
  logic [W-1:0]      mm_a;
  logic [W-1:0]      mm_b;
  logic [W-1:0]      mm_res;
  mexp_pkg::mm_sts_t mm_sts;

  // Operands follow the state; they are steady for the whole multiply since
  // the registers feeding them change only when the unit reports done.
  always_comb begin
    case (state_r)
      mexp_pkg::ST_REDUCE: begin
        mm_a = W'(1);
        mm_b = base_r;
      end
      mexp_pkg::ST_MULT: begin
        mm_a = res_r;
        mm_b = bv_r;
      end
      default: begin
        mm_a = bv_r;
        mm_b = bv_r;
      end
    endcase
  end

  // After a squaring the exponent moves down one bit before the next check.
  assign e_dec = (state_r == mexp_pkg::ST_SQUARE) ? (e_r >> 1) : e_r;

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    bv_nxt    = bv_r;
    res_nxt   = res_r;
    e_nxt     = e_r;
    go_nxt    = 1'b0;
    ov_nxt    = 1'b0;
    ores_nxt  = ores_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          base_nxt  = in_base_value[W-1:0];
          e_nxt     = exponent_r;
          res_nxt   = W'(1);
          go_nxt    = 1'b1;
          state_nxt = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mm_sts.done) begin
          res_nxt   = mm_res;
          go_nxt    = 1'b1;
          state_nxt = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_REDUCE, mexp_pkg::ST_SQUARE: begin
        // Both store the new base, then look at the next exponent bit.
        if (mm_sts.done) begin
          bv_nxt = mm_res;
          e_nxt  = e_dec;
          if (e_dec == '0) begin
            ov_nxt    = 1'b1;
            ores_nxt  = res_r;
            state_nxt = mexp_pkg::ST_IDLE;
          end else if (e_dec[0]) begin
            go_nxt    = 1'b1;
            state_nxt = mexp_pkg::ST_MULT;
          end else begin
            go_nxt    = 1'b1;
            state_nxt = mexp_pkg::ST_SQUARE;
          end
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(1);
      exponent_r <= '0;
      state_r    <= mexp_pkg::ST_IDLE;
      go_r       <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      modulus_r  <= modulus_nxt;
      exponent_r <= exponent_nxt;
      state_r    <= state_nxt;
      go_r       <= go_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    bv_r   <= bv_nxt;
    res_r  <= res_nxt;
    e_r    <= e_nxt;
    ores_r <= ores_nxt;
  end

  mexp_modmul #(
    .WIDTH (W)
  ) u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go_r),
    .a      (mm_a),
    .b      (mm_b),
    .m      (modulus_r),
    .result (mm_res),
    .sts    (mm_sts)
  );

  assign busy              = (state_r != mexp_pkg::ST_IDLE);
  assign out_valid         = ov_r;
  assign out_power_residue = mexp_pkg::DATA_BITS'(ores_r);

endmodule : modular_exponentiation

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking testbench for the modular exponentiation block
// Programs modulus and exponent over the APB-style port, sends base words
// through the start/busy handshake and checks every result word against a
// square-and-multiply predictor that uses full 128-bit products.
// ============================================================================

module tb_top;

  localparam int DATA_BITS = mexp_pkg::DATA_BITS;
  // The block is built with its default operand width.
  localparam int WORD_BITS = 64;
  localparam logic [DATA_BITS-1:0] WORD_MASK = {DATA_BITS{1'b1}} >> (DATA_BITS - WORD_BITS);
  localparam logic [DATA_BITS-1:0] ALL_ONES = {DATA_BITS{1'b1}};

  // The slowest word has an exponent of all ones. All words sent, each at that
  // cost, plus the longest sender gaps stay within this limit.
  localparam int CYCLE_LIMIT = 5_000_000;
  // After the last result, wait somewhat longer than one modular multiply.
  localparam int END_WAIT_CYCLES = 150;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 12;

  // One expected result word, kept with the base that produced it so that a
  // mismatch report can show both.
  typedef struct {
    logic [DATA_BITS-1:0] base;
    logic [DATA_BITS-1:0] residue;
  } residue_entry_t;

  // Every input of the block has a known value from time zero.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [DATA_BITS-1:0] in_base_value = '0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;

  logic                 busy;
  logic                 out_valid;
  logic [DATA_BITS-1:0] out_power_residue;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // The testbench's own copy of the key registers, as they are after reset.
  logic [DATA_BITS-1:0] key_modulus = 64'd1;
  logic [DATA_BITS-1:0] key_exponent = 64'd0;

  // Results still owed by the block, oldest first.
  residue_entry_t pending_residues[$];

  int error_count = 0;
  int cycle_count = 0;
  // Percentage of words before which the sender goes quiet for a while.
  int idle_pct = 0;

  modular_exponentiation #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_power_residue(out_power_residue),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Right-to-left square and multiply. The base is reduced first; each
  // product is formed at double width, so reducing it with a plain modulo is
  // exact. With a zero exponent the loop never runs and the answer is 1, even
  // when the modulus is 1. Any multiply with a modulus of 1 gives 0.
  function automatic logic [DATA_BITS-1:0] predict_residue(input logic [DATA_BITS-1:0] base_in);
    logic [2*DATA_BITS-1:0] product;
    logic [DATA_BITS-1:0]   m;
    logic [DATA_BITS-1:0]   b;
    logic [DATA_BITS-1:0]   e;
    logic [DATA_BITS-1:0]   r;
    m = key_modulus & WORD_MASK;
    if (m == '0) m = 64'd1;
    b = (base_in & WORD_MASK) % m;
    e = key_exponent & WORD_MASK;
    r = 64'd1;
    while (e != '0) begin
      if (e[0]) begin
        product = {64'd0, r} * {64'd0, b};
        r = DATA_BITS'(product % {64'd0, m});
      end
      product = {64'd0, b} * {64'd0, b};
      b = DATA_BITS'(product % {64'd0, m});
      e = e >> 1;
    end
    return r & WORD_MASK;
  endfunction

  // Counts a failure; only the first few are described in full.
  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Result checker. The receiver cannot hold results off, so every cycle with
  // out_valid high carries one word that must match the oldest expectation.
  always @(posedge clk) begin
    residue_entry_t want;
    if (rst_n && out_valid) begin
      if (pending_residues.size() == 0) begin
        note_failure($sformatf("result word %h arrived with nothing expected",
                               out_power_residue));
      end else begin
        want = pending_residues.pop_front();
        if (out_power_residue !== want.residue) begin
          note_failure($sformatf("base %h: expected residue %h, got %h",
                                 want.base, want.residue, out_power_residue));
        end
      end
    end
  end

  // Sends one base word. An optional quiet stretch comes first; its length is
  // spread past one multiply so that it ends at varied points of the
  // block's work. start is left high after the accepting edge, so a word that
  // follows at once costs no extra assignment in the same step.
  task automatic send_base(input logic [DATA_BITS-1:0] base);
    residue_entry_t entry;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 160)) @(posedge clk);
    end
    start         <= 1'b1;
    in_base_value <= base;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: the key registers cannot change while a word is
    // in flight, so the prediction is made now.
    entry.base    = base;
    entry.residue = predict_residue(base);
    pending_residues.push_back(entry);
  endtask

  // Lowers start and waits until every expected word has come back and the
  // block is idle again.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_residues.size() != 0 || busy) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready. The register
  // takes the value at the completing edge; the bus then returns to idle.
  task automatic write_register(input logic idx, input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    kept = value & WORD_MASK;
    if (idx == mexp_pkg::REG_MODULUS) begin
      // A zero modulus is refused; the old one stays.
      if (kept != '0) key_modulus = kept;
    end else begin
      key_exponent = kept;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Straight after reset: modulus 1 and exponent 0 give 1 for any base.
  task automatic test_reset_values();
    send_base('0);
    send_base(ALL_ONES);
    send_base({$urandom, $urandom});
    drain_results();
  endtask

  // A zero exponent gives 1 whatever the base and modulus.
  task automatic test_zero_exponent();
    write_register(mexp_pkg::REG_MODULUS, 64'd97);
    write_register(mexp_pkg::REG_EXPONENT, 64'd0);
    send_base('0);
    send_base(64'd96);
    send_base(ALL_ONES);
    drain_results();
  endtask

  // Modulus 1 with a nonzero exponent gives 0.
  task automatic test_modulus_one();
    write_register(mexp_pkg::REG_MODULUS, 64'd1);
    write_register(mexp_pkg::REG_EXPONENT, 64'd5);
    send_base(64'd7);
    drain_results();
    write_register(mexp_pkg::REG_EXPONENT, ALL_ONES);
    send_base(ALL_ONES);
    drain_results();
  endtask

  // Full-width extremes: largest modulus and exponent, bases at and around
  // the modulus, and a power-of-two modulus with the top bit alone set.
  task automatic test_full_width();
    write_register(mexp_pkg::REG_MODULUS, ALL_ONES);
    write_register(mexp_pkg::REG_EXPONENT, ALL_ONES);
    send_base('0);
    send_base(64'd1);
    send_base(64'd2);
    send_base(ALL_ONES - 64'd1);
    send_base(ALL_ONES);
    drain_results();
    write_register(mexp_pkg::REG_EXPONENT, 64'd1);
    send_base(ALL_ONES);
    send_base(64'h8000_0000_0000_0001);
    drain_results();
    write_register(mexp_pkg::REG_MODULUS, 64'h8000_0000_0000_0000);
    write_register(mexp_pkg::REG_EXPONENT, 64'd3);
    send_base(ALL_ONES);
    drain_results();
  endtask

  // Writing zero to the modulus must leave the previous modulus in place.
  task automatic test_zero_modulus_write();
    write_register(mexp_pkg::REG_MODULUS, 64'd1_000_003);
    write_register(mexp_pkg::REG_EXPONENT, 64'd65537);
    write_register(mexp_pkg::REG_MODULUS, '0);
    send_base(64'd123_456_789);
    send_base(ALL_ONES);
    drain_results();
  endtask

  function automatic logic [DATA_BITS-1:0] random_modulus();
    logic [DATA_BITS-1:0] m;
    case ($urandom_range(3))
      0:       m = 64'($urandom_range(2, 255));
      1:       m = 64'($urandom_range(2, 65535));
      2:       m = {$urandom, $urandom};
      default: m = ALL_ONES - 64'($urandom_range(0, 1000));
    endcase
    if (m == '0) m = 64'd1;
    return m;
  endfunction

  // Most exponents are short so the run stays quick; a few span all 64 bits.
  function automatic logic [DATA_BITS-1:0] random_exponent();
    logic [DATA_BITS-1:0] e;
    int                   pick;
    pick = $urandom_range(9);
    e    = {$urandom, $urandom};
    if (pick <= 1) return e;
    if (pick <= 6) return e & (ALL_ONES >> (DATA_BITS - $urandom_range(1, 16)));
    if (pick <= 8) return e & (ALL_ONES >> (DATA_BITS - $urandom_range(17, 32)));
    return 64'($urandom_range(0, 2));
  endfunction

  // Bases are a mix of full-width noise, values already below the modulus
  // and values right at its edge, or else simply 0 or 1.
  function automatic logic [DATA_BITS-1:0] random_base();
    logic [DATA_BITS-1:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0, 1, 2: return b;
      3:       return b % key_modulus;
      4:       return key_modulus + 64'($urandom_range(0, 2)) - 64'd1;
      default: return 64'($urandom_range(0, 1));
    endcase
  endfunction

  // Random keys in several phases, cycling through no idling, a sender quiet
  // before 58 of a hundred words, and one quiet before 26. One phase also
  // pauses in the middle until every word has come back.
  task automatic test_random_keys();
    int idle_choices[3] = '{0, 58, 26};
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_register(mexp_pkg::REG_MODULUS, random_modulus());
      write_register(mexp_pkg::REG_EXPONENT, random_exponent());
      // Now and then a zero write, which the block must refuse.
      if ($urandom_range(3) == 0) write_register(mexp_pkg::REG_MODULUS, '0);
      idle_pct = idle_choices[phase % 3];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_base(random_base());
        if (phase == 1 && n == WORDS_PER_PHASE / 2) drain_results();
      end
      drain_results();
    end
    idle_pct = 0;
  endtask

  // Main sequence: reset once, the directed tests, then the random keys.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_exponent();
    test_modulus_one();
    test_full_width();
    test_zero_modulus_write();
    test_random_keys();

    drain_results();
    repeat (END_WAIT_CYCLES) @(posedge clk);
    if (pending_residues.size() != 0) begin
      note_failure($sformatf("%0d result words never arrived", pending_residues.size()));
    end

    if (error_count == 0) begin
      $display("modular_exponentiation verification clean");
    end else begin
      $display("modular_exponentiation verification failed");
    end
    $finish;
  end

  // Watchdog: a stuck handshake must not hang the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("modular_exponentiation verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/mexp_pkg.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation.sv
tb/sv/tb_top.sv
